// ===== rtl/dsti64_pkg.sv =====
package dsti64_pkg;

  // Result status codes.
  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_POS_OVF   = 2'd1,
    ST_NEG_OVF   = 2'd2,
    ST_MALFORMED = 2'd3
  } status_t;

  // Characters that the parser recognises.
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;

  // Largest magnitude that may still take another digit (limit divided by ten).
  localparam logic signed [63:0] POS_LIM10 = 64'sd922337203685477580;
  localparam logic signed [63:0] NEG_LIM10 = -64'sd922337203685477580;

endpackage

// ===== rtl/decimal_string_to_int64.sv =====
// Streaming ASCII decimal to signed 64-bit converter. A string arrives one byte per beat on the
// in_ channel, with in_last_byte high on its final byte. An optional leading '+' or '-' and the
// digits that follow it are converted; the first non-digit ends the conversion and later bytes
// are ignored. One result beat leaves on the out_ channel for each string, in the cycle after its
// final byte is accepted: the value and a status (0 ok, 1 positive overflow, 2 negative
// underflow, 3 sign without a digit), with the value forced to zero on any error. The block
// takes one byte every cycle: the running value is kept in two's complement and each digit is
// folded in by one shift-and-add (times ten plus or minus the digit) with the limit check on its
// carry bits. A final byte is held back only while the previous result is still stalled in the
// output register; other bytes are always taken.
module decimal_string_to_int64 (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic [7:0]             in_char_byte,
  input  logic                   in_last_byte,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic signed [63:0]     out_int_value,
  output dsti64_pkg::status_t    out_parse_status
);
  import dsti64_pkg::*;

  typedef enum logic [1:0] {
    PH_FIRST = 2'd0,
    PH_SIGN  = 2'd1,
    PH_BODY  = 2'd2
  } phase_t;

  phase_t             phase_r, phase_nxt;
  logic signed [63:0] acc_r, acc_nxt;
  logic               neg_r, neg_nxt;
  logic               stopped_r, stopped_nxt;
  status_t            err_r, err_nxt;

  logic               out_valid_r, out_valid_nxt;
  logic signed [63:0] out_value_r, out_value_nxt;
  status_t            out_status_r, out_status_nxt;

  logic               in_acc;
  logic               is_digit;
  logic               is_sign;
  logic               do_digit;
  logic signed [64:0] acc_ext;
  logic signed [64:0] dig_ext;
  logic signed [64:0] step_sum;
  logic               pre_ovf;
  logic               post_ovf;

  assign in_stall = out_valid_r && out_stall && in_last_byte;
  assign in_acc   = in_valid && !in_stall;

  assign is_digit = (in_char_byte >= CH_ZERO) && (in_char_byte <= CH_NINE);
  assign is_sign  = (in_char_byte == CH_MINUS) || (in_char_byte == CH_PLUS);

  // One digit step: value times ten, plus or minus the digit, in 65 bits.
  assign acc_ext  = {acc_r[63], acc_r};
  assign dig_ext  = neg_r ? -$signed({61'd0, in_char_byte[3:0]})
                          :  $signed({61'd0, in_char_byte[3:0]});
  assign step_sum = (acc_ext <<< 3) + (acc_ext <<< 1) + dig_ext;
  assign pre_ovf  = neg_r ? (acc_r < NEG_LIM10) : (acc_r > POS_LIM10);
  assign post_ovf = neg_r ? (step_sum[64] && !step_sum[63]) : step_sum[63];

  // Parser state update for the byte on the input.
  always_comb begin
    phase_nxt   = phase_r;
    acc_nxt     = acc_r;
    neg_nxt     = neg_r;
    stopped_nxt = stopped_r;
    err_nxt     = err_r;
    do_digit    = 1'b0;
    case (phase_r)
      PH_FIRST: begin
        if (is_sign) begin
          neg_nxt   = (in_char_byte == CH_MINUS);
          phase_nxt = PH_SIGN;
          if (in_last_byte) begin
            err_nxt = ST_MALFORMED;
          end
        end else begin
          phase_nxt = PH_BODY;
          if (is_digit) begin
            do_digit = 1'b1;
          end else begin
            stopped_nxt = 1'b1;
          end
        end
      end
      PH_SIGN: begin
        phase_nxt = PH_BODY;
        if (is_digit) begin
          do_digit = 1'b1;
        end else begin
          err_nxt = ST_MALFORMED;
        end
      end
      default: begin
        if (err_r == ST_OK && !stopped_r) begin
          if (is_digit) begin
            do_digit = 1'b1;
          end else begin
            stopped_nxt = 1'b1;
          end
        end
      end
    endcase

    if (do_digit) begin
      if (pre_ovf || post_ovf) begin
        err_nxt = neg_r ? ST_NEG_OVF : ST_POS_OVF;
      end else begin
        acc_nxt = step_sum[63:0];
      end
    end

    // Result of a finished string.
    out_value_nxt  = (err_nxt != ST_OK) ? 64'sd0 : acc_nxt;
    out_status_nxt = err_nxt;

    // The final byte clears the state for the next string.
    if (in_last_byte) begin
      phase_nxt   = PH_FIRST;
      acc_nxt     = 64'sd0;
      neg_nxt     = 1'b0;
      stopped_nxt = 1'b0;
      err_nxt     = ST_OK;
    end
  end

  // Output register handshake.
  always_comb begin
    if (in_acc && in_last_byte) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  // Parser state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= PH_FIRST;
      acc_r     <= 64'sd0;
      neg_r     <= 1'b0;
      stopped_r <= 1'b0;
      err_r     <= ST_OK;
    end else if (in_acc) begin
      phase_r   <= phase_nxt;
      acc_r     <= acc_nxt;
      neg_r     <= neg_nxt;
      stopped_r <= stopped_nxt;
      err_r     <= err_nxt;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc && in_last_byte) begin
      out_value_r  <= out_value_nxt;
      out_status_r <= out_status_nxt;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_int_value    = out_value_r;
  assign out_parse_status = out_status_r;

endmodule

// ===== rtl/dsti64_checker.sv =====
module dsti64_checker (
  input logic                   clk,
  input logic                   rst_n,
  input logic                   in_valid,
  input logic                   in_stall,
  input logic [7:0]             in_char_byte,
  input logic                   in_last_byte,
  input logic                   out_valid,
  input logic                   out_stall,
  input logic signed [63:0]     out_int_value,
  input dsti64_pkg::status_t    out_parse_status
);
  import dsti64_pkg::*;

  // An error result always carries a zero value.
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_parse_status != ST_OK) |-> (out_int_value == 64'sd0))
    else $error("error result with a non-zero value");

  // An accepted final byte gives a result beat in the next cycle.
  a_last_result: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall && in_last_byte) |=> out_valid)
    else $error("final byte accepted but no result follows");

  // A result only appears after a final byte has been accepted.
  a_no_invented: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_valid && !in_stall && in_last_byte))
    else $error("result beat without a final byte");

  // A stalled result beat holds.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=>
      (out_valid && $stable(out_int_value) && $stable(out_parse_status)))
    else $error("stalled result beat changed");

endmodule

bind decimal_string_to_int64 dsti64_checker u_dsti64_checker (.*);
